FILE: design/wtsp_pkg.sv
package wtsp_pkg;

	localparam int FRACTION_BITS  = 16;
	localparam int MATRIX_ENTRIES = 16;

	localparam int COEF_W    = 32;
	localparam int POS_W     = 32;
	localparam int SCR_W     = 32;
	localparam int CFG_W     = 15;
	localparam int HALF_W    = CFG_W - 1;
	localparam int IDX_W     = $clog2(MATRIX_ENTRIES);
	localparam int CFG_IDX_W = 2;

	// clip accumulator: three floored products plus the scaled translation
	localparam int PROD_FLOOR_W = 64 - FRACTION_BITS;
	localparam int TRANS_W      = COEF_W + FRACTION_BITS;
	localparam int ACC_W        = ((PROD_FLOOR_W > TRANS_W) ? PROD_FLOOR_W : TRANS_W) + 2;
	localparam int W10_W        = ACC_W + 4;

	// ndc quotient: 33 bits, clamped to 2^33
	localparam int QB      = 33;
	localparam int OVF_SH  = QB - FRACTION_BITS;
	localparam int QMAG_W  = QB + 1;
	localparam int NDC_W   = QMAG_W + 1;
	localparam int CNT_W   = $clog2(QB);

	// shared multiplier
	localparam int MUL_A_W = POS_W + 1;
	localparam int MUL_B_W = NDC_W;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_POINT = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;

	localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 15'd1920;
	localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 15'd1080;

	localparam logic [1:0] ROW_X = 2'd0;
	localparam logic [1:0] ROW_Y = 2'd1;
	localparam logic [1:0] ROW_W = 2'd3;

	localparam logic [1:0] COL_FIRST = 2'd0;
	localparam logic [1:0] COL_LAST  = 2'd2;
	localparam logic [1:0] COL_TRANS = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_ACC,
		S_CHK,
		S_DSET,
		S_DIV,
		S_SCL,
		S_SUM,
		S_OUT
	} state_t;

endpackage

FILE: design/world_to_screen_projection_unit.sv
// World-to-screen projection unit.
// Input channel (in_valid/in_ready): a request with kind 0 writes coef_value into
// view-matrix coefficient coef_index (row-major, Q16.16).
// A request with kind 1 projects (pos_x, pos_y, pos_z) and yields one result on
// the output channel (out_valid/out_ready): on_screen, screen_x, screen_y.
// Every coefficient must be written before a projection uses it.
// Config channel (cfg_valid/cfg_ready, always ready): cfg_index 0 sets the
// viewport width, 1 the height; other indexes are ignored. Write only when idle.
// A point that falls behind the near limit skips both divisions and scalings;
// the next point is taken only after the last one has left the final state, a
// load every cycle while idle. One 33x35 multiplier does the nine clip products
// and both viewport scalings; one subtractor forms each ndc quotient at one bit
// per cycle.
// in_ready is high only between requests; a new request is taken while the
// previous result still waits in the output register.
// A stalled receiver holds the result; a finished point waits in the final state
// until the output register is free.
// Reset returns the sequencer to idle, drops out_valid and restores 1920x1080.
// The coefficient store is not reset.
module world_to_screen_projection_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [wtsp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wtsp_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          kind,
	input  logic [wtsp_pkg::IDX_W-1:0]    coef_index,
	input  logic signed [wtsp_pkg::COEF_W-1:0] coef_value,
	input  logic signed [wtsp_pkg::POS_W-1:0]  pos_x,
	input  logic signed [wtsp_pkg::POS_W-1:0]  pos_y,
	input  logic signed [wtsp_pkg::POS_W-1:0]  pos_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          on_screen,
	output logic signed [wtsp_pkg::SCR_W-1:0]  screen_x,
	output logic signed [wtsp_pkg::SCR_W-1:0]  screen_y
);
	import wtsp_pkg::*;

	localparam logic signed [PROD_W-1:0] SAT_MAX =
		{{(PROD_W-SCR_W+1){1'b0}}, {(SCR_W-1){1'b1}}};
	localparam logic signed [PROD_W-1:0] SAT_MIN =
		{{(PROD_W-SCR_W+1){1'b1}}, {(SCR_W-1){1'b0}}};
	localparam logic signed [W10_W-1:0] THRESH = W10_W'(1) << FRACTION_BITS;

	state_t state_q, state_d;

	logic [CFG_W-1:0] width_q, height_q;
	logic [1:0]       row_q, col_q;
	logic             ax_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;

	logic signed [COEF_W-1:0] coef_mem [MATRIX_ENTRIES];
	logic signed [POS_W-1:0]  pos_x_q, pos_y_q, pos_z_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q, cx_q, cy_q, cw_q;
	logic                     neg_q, ovf_q, on_q;
	logic [ACC_W-1:0]         r_q;
	logic [QB-1:0]            nb_q, q_q;
	logic signed [SCR_W-1:0]  sx_q, sy_q;
	logic                     on_screen_q;
	logic signed [SCR_W-1:0]  screen_x_q, screen_y_q;

	logic [IDX_W-1:0]          rd_addr;
	logic signed [COEF_W-1:0]  coef_rd;
	logic signed [POS_W-1:0]   pos_sel;
	logic [HALF_W-1:0]         half;
	logic [QMAG_W-1:0]         qmag;
	logic signed [NDC_W-1:0]   ndc;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  mul_p;
	logic signed [ACC_W-1:0]   prod_f, trans, acc_base, acc_sum;
	logic signed [W10_W-1:0]   w10;
	logic                      off;
	logic signed [ACC_W-1:0]   cdiv;
	logic                      cneg;
	logic [ACC_W-1:0]          mag, cw_u, shifted, diff;
	logic [ACC_W+FRACTION_BITS-1:0] n_full;
	logic                      ovf_cmp, ge;
	logic signed [PROD_W-1:0]  half_f, sum;
	logic signed [SCR_W-1:0]   sat;
	logic                      out_free;

	// shared datapath
	always_comb begin
		rd_addr = (state_q == S_ACC) ? {row_q, COL_TRANS} : {row_q, col_q};
		coef_rd = coef_mem[rd_addr];
		case (col_q)
			2'd0:    pos_sel = pos_x_q;
			2'd1:    pos_sel = pos_y_q;
			default: pos_sel = pos_z_q;
		endcase
		half = ax_q ? height_q[CFG_W-1:1] : width_q[CFG_W-1:1];
		qmag = ovf_q ? {1'b1, {QB{1'b0}}} : {1'b0, q_q};
		ndc  = neg_q ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});

		if (state_q == S_SCL) begin
			mul_a = $signed({{(MUL_A_W-HALF_W){1'b0}}, half});
			mul_b = ndc;
		end else begin
			mul_a = $signed({pos_sel[POS_W-1], pos_sel});
			mul_b = $signed({{(MUL_B_W-COEF_W){coef_rd[COEF_W-1]}}, coef_rd});
		end
		mul_p = mul_a * mul_b;

		prod_f   = ACC_W'(prod_q >>> FRACTION_BITS);
		trans    = ACC_W'(coef_rd) <<< FRACTION_BITS;
		acc_base = (col_q == COL_FIRST) ? '0 : acc_q;
		acc_sum  = acc_base + prod_f + ((col_q == COL_LAST) ? trans : '0);

		w10 = (W10_W'(cw_q) <<< 3) + (W10_W'(cw_q) <<< 1);
		off = w10 < THRESH;

		cdiv    = ax_q ? cy_q : cx_q;
		cneg    = cdiv[ACC_W-1];
		mag     = cneg ? ACC_W'(-cdiv) : ACC_W'(cdiv);
		cw_u    = $unsigned(cw_q);
		n_full  = {mag, {FRACTION_BITS{1'b0}}};
		ovf_cmp = {{OVF_SH{1'b0}}, mag} >= {cw_u, {OVF_SH{1'b0}}};
		shifted = {r_q[ACC_W-2:0], nb_q[QB-1]};
		ge      = shifted >= cw_u;
		diff    = shifted - cw_u;

		half_f = $signed(PROD_W'(half) << FRACTION_BITS);
		sum    = ax_q ? (half_f - prod_q) : (half_f + prod_q);
		if (sum > SAT_MAX)
			sat = SAT_MAX[SCR_W-1:0];
		else if (sum < SAT_MIN)
			sat = SAT_MIN[SCR_W-1:0];
		else
			sat = sum[SCR_W-1:0];

		out_free = !out_valid_q || out_ready;
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid && kind == KIND_POINT)
					state_d = S_MUL;
			end
			S_MUL:  state_d = S_ACC;
			S_ACC: begin
				if (col_q == COL_LAST && row_q == ROW_W)
					state_d = S_CHK;
				else
					state_d = S_MUL;
			end
			S_CHK:  state_d = off ? S_OUT : S_DSET;
			S_DSET: state_d = S_DIV;
			S_DIV: begin
				if (cnt_q == '0)
					state_d = S_SCL;
			end
			S_SCL:  state_d = S_SUM;
			S_SUM:  state_d = ax_q ? S_OUT : S_DSET;
			S_OUT: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			width_q     <= SCREEN_WIDTH_RST;
			height_q    <= SCREEN_HEIGHT_RST;
			row_q       <= ROW_X;
			col_q       <= COL_FIRST;
			ax_q        <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				case (cfg_index)
					CFG_SCREEN_WIDTH:  width_q  <= cfg_data;
					CFG_SCREEN_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					row_q <= ROW_X;
					col_q <= COL_FIRST;
					ax_q  <= 1'b0;
				end
				S_ACC: begin
					if (col_q == COL_LAST) begin
						col_q <= COL_FIRST;
						row_q <= (row_q == ROW_X) ? ROW_Y : ROW_W;
					end else begin
						col_q <= col_q + 2'd1;
					end
				end
				S_DSET: cnt_q <= CNT_W'(QB - 1);
				S_DIV: begin
					if (cnt_q != '0)
						cnt_q <= cnt_q - 1'b1;
				end
				S_SUM: ax_q <= 1'b1;
				default: ;
			endcase
			if (state_q == S_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (kind == KIND_LOAD) begin
						coef_mem[coef_index] <= coef_value;
					end else begin
						pos_x_q <= pos_x;
						pos_y_q <= pos_y;
						pos_z_q <= pos_z;
					end
				end
			end
			S_MUL, S_SCL: prod_q <= mul_p;
			S_ACC: begin
				acc_q <= acc_sum;
				if (col_q == COL_LAST) begin
					case (row_q)
						ROW_X:   cx_q <= acc_sum;
						ROW_Y:   cy_q <= acc_sum;
						default: cw_q <= acc_sum;
					endcase
				end
			end
			S_CHK: begin
				on_q <= !off;
				sx_q <= '0;
				sy_q <= '0;
			end
			S_DSET: begin
				neg_q <= cneg;
				ovf_q <= ovf_cmp;
				r_q   <= ACC_W'(n_full[ACC_W+FRACTION_BITS-1:QB]);
				nb_q  <= n_full[QB-1:0];
			end
			S_DIV: begin
				r_q  <= ge ? diff : shifted;
				nb_q <= nb_q << 1;
				q_q  <= {q_q[QB-2:0], ge};
			end
			S_SUM: begin
				if (ax_q)
					sy_q <= sat;
				else
					sx_q <= sat;
			end
			S_OUT: begin
				if (out_free) begin
					on_screen_q <= on_q;
					screen_x_q  <= sx_q;
					screen_y_q  <= sy_q;
				end
			end
			default: ;
		endcase
	end

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign on_screen = on_screen_q;
	assign screen_x  = screen_x_q;
	assign screen_y  = screen_y_q;

`ifndef NO_ASSERTIONS
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_free) |=> out_valid)
		else $error("finished result not presented");

	a_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !on_screen) |-> (screen_x == '0 && screen_y == '0))
		else $error("off-screen result with nonzero coordinates");

	a_div_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (!cw_q[ACC_W-1] && cw_q != '0))
		else $error("division by non-positive w");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && kind == KIND_LOAD) |=> (state_q == S_IDLE))
		else $error("coefficient load left idle");
`endif

endmodule
